// ===== hdl/tsf_pkg.sv =====
`default_nettype none
package tsf_pkg;

   localparam int unsigned PID_WIDTH   = 13;
   localparam int unsigned CSR_WIDTH   = PID_WIDTH;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

   // Payload bytes at or past this position are never part of a section.
   localparam logic [7:0]  TS_BODY_END = 8'd188;

   localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   localparam logic [12:0] TARGET_PID_RESET = 13'h001f;
   localparam logic [7:0]  TABLE_ID_RESET   = 8'h7f;

   typedef enum logic [0:0] {
      CSR_TARGET_PID = 1'b0,
      CSR_TABLE_ID   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_CRC_ERR   = 2'd1,
      STATUS_TRUNCATED = 2'd2
   } status_type;

   // What the packet parser tells the section engine about one byte.
   typedef enum logic [1:0] {
      EV_PKT_START  = 2'd0,
      EV_UNIT_START = 2'd1,
      EV_ARM        = 2'd2,
      EV_DATA       = 2'd3
   } event_kind_type;

   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     data;
      logic           unit_start;
   } event_type;

   // One byte of CRC-32/MPEG-2, MSB first.
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'h0};
      for (int k = 0; k < 8; k++) begin
         if (c[31]) begin
            c = {c[30:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[30:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/tsf_req_if.sv =====
`default_nettype none
interface tsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ts_byte;
   logic       packet_start;

   modport source (output valid, ts_byte, packet_start, input ready);
   modport sink   (input valid, ts_byte, packet_start, output ready);
endinterface
`default_nettype wire

// ===== hdl/tsf_rsp_if.sv =====
`default_nettype none
interface tsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] section_byte;
   logic       data_valid;
   logic       last;
   logic [1:0] status;

   modport source (output valid, section_byte, data_valid, last, status, input ready);
   modport sink   (input valid, section_byte, data_valid, last, status, output ready);
endinterface
`default_nettype wire

// ===== hdl/tsf_front.sv =====
`default_nettype none
module tsf_front #(
   parameter int unsigned PACKET_LENGTH = 188
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   tsf_req_if.sink                        req_ch,
   input  wire logic [tsf_pkg::PID_WIDTH-1:0] target_pid,
   input  wire logic                      queue_full,
   output logic                           ev_push,
   output tsf_pkg::event_type             ev_data
);
   import tsf_pkg::*;

   localparam logic [7:0] PKT_LEN = 8'(PACKET_LENGTH);

   logic [7:0] pos_ff, pos_in;
   logic [4:0] pid_hi_ff, pid_hi_in;
   logic       uss_ff, uss_in;
   logic       accepted_ff, accepted_in;
   logic       adapt_ff, adapt_in;
   logic       pointer_ff, pointer_in;
   logic [7:0] skip_ff, skip_in;
   logic       accept;
   logic [7:0] b;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign b            = req_ch.ts_byte;

   always_comb begin
      pos_in      = pos_ff;
      pid_hi_in   = pid_hi_ff;
      uss_in      = uss_ff;
      accepted_in = accepted_ff;
      adapt_in    = adapt_ff;
      pointer_in  = pointer_ff;
      skip_in     = skip_ff;
      ev_push     = 1'b0;
      ev_data.kind       = EV_DATA;
      ev_data.data       = b;
      ev_data.unit_start = uss_ff;

      if (req_ch.packet_start) begin
         pos_in = 8'd0;
      end else if (pos_ff < PKT_LEN) begin
         pos_in = pos_ff + 8'd1;
      end else begin
         pos_in = PKT_LEN;
      end

      priority if (pos_in == 8'd0) begin
         accepted_in  = 1'b0;
         adapt_in     = 1'b0;
         pointer_in   = 1'b0;
         skip_in      = 8'd0;
         ev_push      = 1'b1;
         ev_data.kind = EV_PKT_START;
      end else if (pos_in == 8'd1) begin
         uss_in    = b[6];
         pid_hi_in = b[4:0];
      end else if (pos_in == 8'd2) begin
         accepted_in = ({pid_hi_ff, b} == target_pid);
      end else if (pos_in == 8'd3) begin
         if (accepted_ff) begin
            if (!b[4]) begin
               accepted_in = 1'b0;
            end else begin
               adapt_in = b[5];
               if (uss_ff) begin
                  pointer_in   = 1'b1;
                  ev_push      = 1'b1;
                  ev_data.kind = EV_UNIT_START;
               end
            end
         end
      end else if (pos_in < TS_BODY_END && accepted_ff) begin
         priority if (adapt_ff) begin
            adapt_in = 1'b0;
            skip_in  = b;
         end else if (skip_ff != 8'd0) begin
            skip_in = skip_ff - 8'd1;
         end else if (pointer_ff) begin
            pointer_in   = 1'b0;
            skip_in      = b;
            ev_push      = 1'b1;
            ev_data.kind = EV_ARM;
         end else begin
            ev_push      = 1'b1;
            ev_data.kind = EV_DATA;
         end
      end else begin
         ev_push = 1'b0;
      end

      ev_push = ev_push && accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= 8'd0;
         pid_hi_ff   <= 5'd0;
         uss_ff      <= 1'b0;
         accepted_ff <= 1'b0;
         adapt_ff    <= 1'b0;
         pointer_ff  <= 1'b0;
         skip_ff     <= 8'd0;
      end else if (accept) begin
         pos_ff      <= pos_in;
         pid_hi_ff   <= pid_hi_in;
         uss_ff      <= uss_in;
         accepted_ff <= accepted_in;
         adapt_ff    <= adapt_in;
         pointer_ff  <= pointer_in;
         skip_ff     <= skip_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/tsf_queue.sv =====
`default_nettype none
module tsf_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tsf_pkg::event_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output logic                    head_valid,
   output tsf_pkg::event_type      head_data
);
   import tsf_pkg::*;

   event_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_WIDTH:0]   count_ff, count_in;
   logic                  do_pop;

   assign full       = (count_ff == (QPTR_WIDTH + 1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/tsf_back.sv =====
`default_nettype none
module tsf_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [7:0]         wanted_table_id,
   input  wire logic               ev_valid,
   input  wire tsf_pkg::event_type ev,
   output logic                    ev_pop,
   tsf_rsp_if.source               rsp_ch
);
   import tsf_pkg::*;

   logic        in_section_ff, in_section_in;
   logic        armed_ff, armed_in;
   logic [1:0]  idx_ff, idx_in;
   logic [3:0]  len_hi_ff, len_hi_in;
   logic [12:0] remaining_ff, remaining_in;
   logic [31:0] crc_ff, crc_in;

   logic        out_valid_ff;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_dv_ff, out_dv_in;
   logic        out_last_ff, out_last_in;
   status_type  out_status_ff, out_status_in;

   logic        emit;
   logic        out_ready;
   logic        done;
   logic [31:0] crc_next;

   assign out_ready = !out_valid_ff || rsp_ch.ready;
   assign ev_pop    = ev_valid && (!emit || out_ready);
   assign crc_next  = crc32_byte(crc_ff, ev.data);

   always_comb begin
      in_section_in = in_section_ff;
      armed_in      = armed_ff;
      idx_in        = idx_ff;
      len_hi_in     = len_hi_ff;
      remaining_in  = remaining_ff;
      crc_in        = crc_ff;
      emit          = 1'b0;
      done          = 1'b0;
      out_byte_in   = ev.data;
      out_dv_in     = 1'b1;
      out_last_in   = 1'b0;
      out_status_in = STATUS_OK;

      unique case (ev.kind)
         EV_PKT_START: begin
            armed_in = 1'b0;
         end
         EV_ARM: begin
            armed_in = 1'b1;
         end
         EV_UNIT_START: begin
            if (in_section_ff) begin
               emit          = 1'b1;
               out_byte_in   = 8'd0;
               out_dv_in     = 1'b0;
               out_last_in   = 1'b1;
               out_status_in = STATUS_TRUNCATED;
               in_section_in = 1'b0;
               idx_in        = 2'd0;
               remaining_in  = 13'd0;
               len_hi_in     = 4'd0;
               crc_in        = CRC_INIT;
            end
         end
         EV_DATA: begin
            if (!in_section_ff) begin
               if (armed_ff) begin
                  armed_in = 1'b0;
                  if (ev.data == wanted_table_id) begin
                     emit          = 1'b1;
                     in_section_in = 1'b1;
                     crc_in        = crc32_byte(CRC_INIT, ev.data);
                     idx_in        = 2'd1;
                  end
               end
            end else begin
               emit   = 1'b1;
               crc_in = crc_next;
               unique case (idx_ff)
                  2'd1: begin
                     len_hi_in = ev.data[3:0];
                     idx_in    = 2'd2;
                  end
                  2'd2: begin
                     remaining_in = {1'b0, len_hi_ff, ev.data};
                     idx_in       = 2'd3;
                     done         = ({len_hi_ff, ev.data} == 12'd0);
                  end
                  default: begin
                     if (remaining_ff != 13'd0) begin
                        remaining_in = remaining_ff - 13'd1;
                     end
                     done = (remaining_ff <= 13'd1);
                  end
               endcase
               if (done) begin
                  out_last_in   = 1'b1;
                  out_status_in = (crc_next != 32'd0) ? STATUS_CRC_ERR : STATUS_OK;
                  in_section_in = 1'b0;
                  idx_in        = 2'd0;
                  remaining_in  = 13'd0;
                  len_hi_in     = 4'd0;
                  crc_in        = CRC_INIT;
                  // A unit-start packet may carry the next section right behind.
                  armed_in      = ev.unit_start;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_section_ff <= 1'b0;
         armed_ff      <= 1'b0;
         idx_ff        <= 2'd0;
         len_hi_ff     <= 4'd0;
         remaining_ff  <= 13'd0;
         crc_ff        <= CRC_INIT;
         out_valid_ff  <= 1'b0;
      end else begin
         if (ev_pop) begin
            in_section_ff <= in_section_in;
            armed_ff      <= armed_in;
            idx_ff        <= idx_in;
            len_hi_ff     <= len_hi_in;
            remaining_ff  <= remaining_in;
            crc_ff        <= crc_in;
         end
         if (out_ready) begin
            out_valid_ff <= ev_pop && emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ev_pop && emit) begin
         out_byte_ff   <= out_byte_in;
         out_dv_ff     <= out_dv_in;
         out_last_ff   <= out_last_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.section_byte = out_byte_ff;
   assign rsp_ch.data_valid   = out_dv_ff;
   assign rsp_ch.last         = out_last_ff;
   assign rsp_ch.status       = out_status_ff;

endmodule
`default_nettype wire

// ===== hdl/ts_section_filter_crc_unit.sv =====
`default_nettype none
// PSI section filter with CRC-32/MPEG-2 check. Transport stream bytes enter on req_ch at one
// byte per cycle while the queue is not full, with packet_start on each sync byte. A packet
// parser follows the header, PID, adaptation field and pointer field and passes one event per
// relevant byte into a four-entry queue; the section engine behind it matches the table id,
// tracks section_length, runs the CRC one byte per cycle unless rsp_ch stalls and writes each
// section byte into an output register on rsp_ch; the queue lets the input flow on while rsp_ch
// is stalled, until its four entries fill. The last byte of a section carries last with status
// ok or CRC error; a new unit start while a section is open yields a marker with data_valid low,
// last high and status truncated. The user must write target_pid and wanted_table_id through
// csr_* only while the stream idles; the block itself does not enforce this.
module ts_section_filter_crc_unit #(
   parameter int unsigned PACKET_LENGTH = 188
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   tsf_req_if.sink                            req_ch,
   tsf_rsp_if.source                          rsp_ch,
   input  wire logic                          csr_we,
   input  wire tsf_pkg::csr_index_type        csr_index,
   input  wire logic [tsf_pkg::CSR_WIDTH-1:0] csr_wdata
);
   import tsf_pkg::*;

   logic [PID_WIDTH-1:0] target_pid_ff;
   logic [7:0]           table_id_ff;
   logic                 queue_full;
   logic                 ev_push;
   event_type            ev_in;
   logic                 ev_valid;
   event_type            ev_head;
   logic                 ev_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_pid_ff <= TARGET_PID_RESET;
         table_id_ff   <= TABLE_ID_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_PID: target_pid_ff <= csr_wdata[PID_WIDTH-1:0];
            CSR_TABLE_ID:   table_id_ff   <= csr_wdata[7:0];
         endcase
      end
   end

   tsf_front #(
      .PACKET_LENGTH (PACKET_LENGTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .target_pid (target_pid_ff),
      .queue_full (queue_full),
      .ev_push    (ev_push),
      .ev_data    (ev_in)
   );

   tsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (ev_push),
      .push_data  (ev_in),
      .full       (queue_full),
      .pop        (ev_pop),
      .head_valid (ev_valid),
      .head_data  (ev_head)
   );

   tsf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .wanted_table_id (table_id_ff),
      .ev_valid        (ev_valid),
      .ev              (ev_head),
      .ev_pop          (ev_pop),
      .rsp_ch          (rsp_ch)
   );

endmodule
`default_nettype wire
